// ===== rtl/pgl_pkg.sv =====
// Shared constants, stage types and digit helpers for the grid locator pipeline.
`default_nettype none
package pgl_pkg;

  localparam int unsigned RAW_W  = 24;
  localparam int unsigned MAG_W  = 23;
  localparam int unsigned OFF_W  = 24;

  localparam logic [23:0] FULL_SCALE     = 24'd8388607;
  localparam logic [22:0] HALF_SCALE     = 23'd4194303;
  localparam logic [23:0] MOST_NEG_RAW   = 24'h800000;
  localparam logic [26:0] LAT_UDEG_SCALE = 27'd90000000;
  localparam logic [27:0] LON_UDEG_SCALE = 28'd180000000;
  localparam logic [6:0]  LAT_DEG        = 7'd90;
  localparam logic [7:0]  LON_DEG        = 8'd180;
  localparam logic [11:0] SUB_SCALE      = 12'd2160;

  localparam logic [7:0]  DIV10_MUL      = 8'd205;
  localparam int unsigned DIV10_SHIFT    = 11;
  localparam int unsigned DIV20_SHIFT    = 12;
  localparam logic [9:0]  DIV3_MUL       = 10'd683;
  localparam int unsigned DIV3_SHIFT     = 11;
  localparam logic [4:0]  FIELD_LON_DIV  = 5'd20;
  localparam logic [3:0]  FIELD_LAT_DIV  = 4'd10;
  localparam logic [1:0]  SUB_DIV3       = 2'd3;

  localparam logic [6:0]  CHAR_UPPER_A   = 7'd65;
  localparam logic [5:0]  CHAR_DIGIT_0   = 6'd48;
  localparam logic [6:0]  CHAR_LOWER_A   = 7'd97;
  localparam logic [6:0]  CHAR_UPPER_S   = 7'd83;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [3:0]       src;
    logic [3:0]       sta;
    logic             lat_neg;
    logic             lon_neg;
    logic [MAG_W-1:0] lat_mag;
    logic [MAG_W-1:0] lon_mag;
    logic [OFF_W-1:0] lat_off;
    logic [OFF_W-1:0] lon_off;
  } prep_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [3:0]  src;
    logic [3:0]  sta;
    logic        lat_neg;
    logic        lon_neg;
    logic [49:0] lat_num;
    logic [50:0] lon_num;
    logic [30:0] plat_num;
    logic [31:0] plon_num;
    logic [35:0] slat_num;
    logic [35:0] slon_num;
  } prod_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [3:0]  src;
    logic [3:0]  sta;
    logic        lat_neg;
    logic        lon_neg;
    logic [26:0] lat_q;
    logic [27:0] lon_q;
    logic [7:0]  plat;
    logic [8:0]  plon;
    logic [12:0] slat;
    logic [12:0] slon;
  } quo_t;

endpackage
`default_nettype wire

// ===== rtl/pgl_prep.sv =====
// Stage 1: beat capture, nibble split, saturation, magnitude and offset forms.
`default_nettype none
module pgl_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [7:0]                   type_byte,
  input  wire logic [7:0]                   flags_byte,
  input  wire logic [pgl_pkg::RAW_W-1:0]    lat_raw,
  input  wire logic [pgl_pkg::RAW_W-1:0]    lon_raw,
  output pgl_pkg::prep_t                    stage_r
);

  pgl_pkg::prep_t          stage_nxt;
  logic [pgl_pkg::RAW_W-1:0] lat_sat;
  logic [pgl_pkg::RAW_W-1:0] lon_sat;
  logic [pgl_pkg::RAW_W-1:0] lat_abs;
  logic [pgl_pkg::RAW_W-1:0] lon_abs;

  always_comb begin
    lat_sat = (lat_raw == pgl_pkg::MOST_NEG_RAW) ? (~pgl_pkg::FULL_SCALE + 24'd1) : lat_raw;
    lon_sat = (lon_raw == pgl_pkg::MOST_NEG_RAW) ? (~pgl_pkg::FULL_SCALE + 24'd1) : lon_raw;
    lat_abs = lat_sat[23] ? (~lat_sat + 24'd1) : lat_sat;
    lon_abs = lon_sat[23] ? (~lon_sat + 24'd1) : lon_sat;

    stage_nxt.valid   = accept;
    stage_nxt.ok      = flags_byte[7];
    stage_nxt.src     = type_byte[7:4];
    stage_nxt.sta     = type_byte[3:0];
    stage_nxt.lat_neg = lat_sat[23];
    stage_nxt.lon_neg = lon_sat[23];
    stage_nxt.lat_mag = lat_abs[pgl_pkg::MAG_W-1:0];
    stage_nxt.lon_mag = lon_abs[pgl_pkg::MAG_W-1:0];
    stage_nxt.lat_off = lat_sat + pgl_pkg::FULL_SCALE;
    stage_nxt.lon_off = lon_sat + pgl_pkg::FULL_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pgl_scale.sv =====
// Stages 2 and 3: constant multiplies, then exact division by the full-scale value.
`default_nettype none
module pgl_scale (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire pgl_pkg::prep_t prep_i,
  output pgl_pkg::quo_t  quo_r
);

  pgl_pkg::prod_t prod_nxt;
  pgl_pkg::prod_t prod_r;
  pgl_pkg::quo_t  quo_nxt;
  logic [28:0]    lat_div;
  logic [28:0]    lon_div;
  logic [28:0]    plat_div;
  logic [28:0]    plon_div;
  logic [28:0]    slat_div;
  logic [28:0]    slon_div;

  // floor(x / (2^23 - 1)) by folding the high part back onto the low part
  function automatic logic [28:0] div_full_scale(input logic [51:0] x);
    logic [28:0] hi;
    logic [29:0] fold1;
    logic [6:0]  carry;
    logic [23:0] fold2;
    logic [28:0] q;
    hi    = x[51:23];
    fold1 = 30'(hi) + 30'(x[22:0]);
    carry = fold1[29:23];
    fold2 = 24'(carry) + 24'(fold1[22:0]);
    q     = hi + 29'(carry) + 29'(fold2 >= pgl_pkg::FULL_SCALE);
    return q;
  endfunction

  always_comb begin
    prod_nxt.valid    = prep_i.valid;
    prod_nxt.ok       = prep_i.ok;
    prod_nxt.src      = prep_i.src;
    prod_nxt.sta      = prep_i.sta;
    prod_nxt.lat_neg  = prep_i.lat_neg;
    prod_nxt.lon_neg  = prep_i.lon_neg;
    prod_nxt.lat_num  = 50'(pgl_pkg::LAT_UDEG_SCALE) * 50'(prep_i.lat_mag)
                        + 50'(pgl_pkg::HALF_SCALE);
    prod_nxt.lon_num  = 51'(pgl_pkg::LON_UDEG_SCALE) * 51'(prep_i.lon_mag)
                        + 51'(pgl_pkg::HALF_SCALE);
    prod_nxt.plat_num = 31'(pgl_pkg::LAT_DEG) * 31'(prep_i.lat_off);
    prod_nxt.plon_num = 32'(pgl_pkg::LON_DEG) * 32'(prep_i.lon_off);
    prod_nxt.slat_num = 36'(pgl_pkg::SUB_SCALE) * 36'(prep_i.lat_off);
    prod_nxt.slon_num = 36'(pgl_pkg::SUB_SCALE) * 36'(prep_i.lon_off);
  end

  always_comb begin
    lat_div  = div_full_scale(52'(prod_r.lat_num));
    lon_div  = div_full_scale(52'(prod_r.lon_num));
    plat_div = div_full_scale(52'(prod_r.plat_num));
    plon_div = div_full_scale(52'(prod_r.plon_num));
    slat_div = div_full_scale(52'(prod_r.slat_num));
    slon_div = div_full_scale(52'(prod_r.slon_num));

    quo_nxt.valid   = prod_r.valid;
    quo_nxt.ok      = prod_r.ok;
    quo_nxt.src     = prod_r.src;
    quo_nxt.sta     = prod_r.sta;
    quo_nxt.lat_neg = prod_r.lat_neg;
    quo_nxt.lon_neg = prod_r.lon_neg;
    quo_nxt.lat_q   = lat_div[26:0];
    quo_nxt.lon_q   = lon_div[27:0];
    quo_nxt.plat    = plat_div[7:0];
    quo_nxt.plon    = plon_div[8:0];
    quo_nxt.slat    = slat_div[12:0];
    quo_nxt.slon    = slon_div[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
      quo_r  <= '0;
    end else begin
      prod_r <= prod_nxt;
      quo_r  <= quo_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pgl_fmt.sv =====
// Stage 4: signed microdegrees and locator character split into the result register.
`default_nettype none
module pgl_fmt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire pgl_pkg::quo_t quo_i,
  output logic              valid_r,
  output logic [3:0]        source_kind_r,
  output logic [3:0]        station_kind_r,
  output logic              position_ok_r,
  output logic signed [27:0] lat_microdeg_r,
  output logic signed [28:0] lon_microdeg_r,
  output logic [6:0]        field_lon_char_r,
  output logic [6:0]        field_lat_char_r,
  output logic [5:0]        square_lon_char_r,
  output logic [5:0]        square_lat_char_r,
  output logic [6:0]        sub_lon_char_r,
  output logic [6:0]        sub_lat_char_r
);

  logic [16:0] flon_prod;
  logic [4:0]  flon_q;
  logic [8:0]  flon_rem;
  logic [15:0] flat_prod;
  logic [4:0]  flat_q;
  logic [7:0]  flat_rem;
  logic [9:0]  slon_hi;
  logic [20:0] slon_prod;
  logic [7:0]  slon_q3;
  logic [9:0]  slon_r3;
  logic [9:0]  slat_hi;
  logic [20:0] slat_prod;
  logic [7:0]  slat_q3;
  logic [9:0]  slat_r3;
  logic [27:0] lat_md;
  logic [28:0] lon_md;

  logic        valid_nxt;
  logic signed [27:0] lat_microdeg_nxt;
  logic signed [28:0] lon_microdeg_nxt;
  logic [6:0]  field_lon_char_nxt;
  logic [6:0]  field_lat_char_nxt;
  logic [5:0]  square_lon_char_nxt;
  logic [5:0]  square_lat_char_nxt;
  logic [6:0]  sub_lon_char_nxt;
  logic [6:0]  sub_lat_char_nxt;

  always_comb begin
    flon_prod = 17'(quo_i.plon) * 17'(pgl_pkg::DIV10_MUL);
    flon_q    = 5'(flon_prod >> pgl_pkg::DIV20_SHIFT);
    flon_rem  = quo_i.plon - 9'(flon_q) * 9'(pgl_pkg::FIELD_LON_DIV);

    flat_prod = 16'(quo_i.plat) * 16'(pgl_pkg::DIV10_MUL);
    flat_q    = 5'(flat_prod >> pgl_pkg::DIV10_SHIFT);
    flat_rem  = quo_i.plat - 8'(flat_q) * 8'(pgl_pkg::FIELD_LAT_DIV);

    slon_hi   = quo_i.slon[12:3];
    slon_prod = 21'(slon_hi) * 21'(pgl_pkg::DIV3_MUL);
    slon_q3   = 8'(slon_prod >> pgl_pkg::DIV3_SHIFT);
    slon_r3   = slon_hi - 10'(slon_q3) * 10'(pgl_pkg::SUB_DIV3);

    slat_hi   = quo_i.slat[12:3];
    slat_prod = 21'(slat_hi) * 21'(pgl_pkg::DIV3_MUL);
    slat_q3   = 8'(slat_prod >> pgl_pkg::DIV3_SHIFT);
    slat_r3   = slat_hi - 10'(slat_q3) * 10'(pgl_pkg::SUB_DIV3);

    lat_md = quo_i.lat_neg ? (~28'(quo_i.lat_q) + 28'd1) : 28'(quo_i.lat_q);
    lon_md = quo_i.lon_neg ? (~29'(quo_i.lon_q) + 29'd1) : 29'(quo_i.lon_q);

    valid_nxt = quo_i.valid;
    if (quo_i.ok) begin
      lat_microdeg_nxt    = $signed(lat_md);
      lon_microdeg_nxt    = $signed(lon_md);
      field_lon_char_nxt  = pgl_pkg::CHAR_UPPER_A + 7'(flon_q);
      field_lat_char_nxt  = pgl_pkg::CHAR_UPPER_A + 7'(flat_q);
      square_lon_char_nxt = pgl_pkg::CHAR_DIGIT_0 + 6'(flon_rem[4:1]);
      square_lat_char_nxt = pgl_pkg::CHAR_DIGIT_0 + 6'(flat_rem[3:0]);
      sub_lon_char_nxt    = pgl_pkg::CHAR_LOWER_A + 7'({slon_r3[1:0], quo_i.slon[2:0]});
      sub_lat_char_nxt    = pgl_pkg::CHAR_LOWER_A + 7'({slat_r3[1:0], quo_i.slat[2:0]});
    end else begin
      lat_microdeg_nxt    = '0;
      lon_microdeg_nxt    = '0;
      field_lon_char_nxt  = '0;
      field_lat_char_nxt  = '0;
      square_lon_char_nxt = '0;
      square_lat_char_nxt = '0;
      sub_lon_char_nxt    = '0;
      sub_lat_char_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    source_kind_r     <= quo_i.src;
    station_kind_r    <= quo_i.sta;
    position_ok_r     <= quo_i.ok;
    lat_microdeg_r    <= lat_microdeg_nxt;
    lon_microdeg_r    <= lon_microdeg_nxt;
    field_lon_char_r  <= field_lon_char_nxt;
    field_lat_char_r  <= field_lat_char_nxt;
    square_lon_char_r <= square_lon_char_nxt;
    square_lat_char_r <= square_lat_char_nxt;
    sub_lon_char_r    <= sub_lon_char_nxt;
    sub_lat_char_r    <= sub_lat_char_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/position_to_grid_locator_top.sv =====
// Position record to microdegrees and six-character grid locator, four-stage pipeline.
// A record is taken on any cycle with start high; busy never rises, so one record per
// clock is sustained. Each result appears on the out_ ports for one cycle with out_valid
// high, exactly four cycles after its start beat, and must be captured then. The latency
// is set by the four register stages: saturation and offset, constant multiplies,
// folding division by the full-scale value, and locator digit split into the output
// register.
`default_nettype none
module position_to_grid_locator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [7:0]         in_type_byte,
  input  wire logic [7:0]         in_flags_byte,
  input  wire logic signed [23:0] in_lat_raw,
  input  wire logic signed [23:0] in_lon_raw,
  output logic                    out_valid,
  output logic [3:0]              out_source_kind,
  output logic [3:0]              out_station_kind,
  output logic                    out_position_ok,
  output logic signed [27:0]      out_lat_microdeg,
  output logic signed [28:0]      out_lon_microdeg,
  output logic [6:0]              out_field_lon_char,
  output logic [6:0]              out_field_lat_char,
  output logic [5:0]              out_square_lon_char,
  output logic [5:0]              out_square_lat_char,
  output logic [6:0]              out_sub_lon_char,
  output logic [6:0]              out_sub_lat_char
);

  pgl_pkg::prep_t prep_r;
  pgl_pkg::quo_t  quo_r;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  pgl_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .type_byte  (in_type_byte),
    .flags_byte (in_flags_byte),
    .lat_raw    (in_lat_raw),
    .lon_raw    (in_lon_raw),
    .stage_r    (prep_r)
  );

  pgl_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .prep_i (prep_r),
    .quo_r  (quo_r)
  );

  pgl_fmt u_fmt (
    .clk               (clk),
    .rst_n             (rst_n),
    .quo_i             (quo_r),
    .valid_r           (out_valid),
    .source_kind_r     (out_source_kind),
    .station_kind_r    (out_station_kind),
    .position_ok_r     (out_position_ok),
    .lat_microdeg_r    (out_lat_microdeg),
    .lon_microdeg_r    (out_lon_microdeg),
    .field_lon_char_r  (out_field_lon_char),
    .field_lat_char_r  (out_field_lat_char),
    .square_lon_char_r (out_square_lon_char),
    .square_lat_char_r (out_square_lat_char),
    .sub_lon_char_r    (out_sub_lon_char),
    .sub_lat_char_r    (out_sub_lat_char)
  );

  a_result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without a start beat four cycles earlier");

  a_header_carried: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_source_kind == $past(in_type_byte[7:4], 4)) &&
                  (out_station_kind == $past(in_type_byte[3:0], 4)) &&
                  (out_position_ok == $past(in_flags_byte[7], 4)))
    else $error("type or flags fields lost on the way through the pipeline");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_position_ok) |->
      (out_lat_microdeg == 28'sd0) && (out_lon_microdeg == 29'sd0) &&
      (out_field_lon_char == 7'd0) && (out_sub_lat_char == 7'd0))
    else $error("invalid record gave nonzero position fields");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_position_ok) |->
      (out_field_lat_char >= pgl_pkg::CHAR_UPPER_A) &&
      (out_field_lat_char <= pgl_pkg::CHAR_UPPER_S) &&
      (out_field_lon_char >= pgl_pkg::CHAR_UPPER_A) &&
      (out_field_lon_char <= pgl_pkg::CHAR_UPPER_S))
    else $error("field character outside A to S");

endmodule
`default_nettype wire
